@@ sv/sdce_pkg.sv @@
package sdce_pkg;

  // status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_COMM    = 3'd4;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  // register indexes
  localparam logic [1:0] REG_POLL_LIMIT = 2'd0;
  localparam logic [1:0] REG_CRC_CMD0   = 2'd1;
  localparam logic [1:0] REG_CRC_CMD8   = 2'd2;

  localparam logic [8:0] POLL_LIMIT_RST = 9'd256;
  localparam logic [7:0] CRC_CMD0_RST   = 8'd149;
  localparam logic [7:0] CRC_CMD8_RST   = 8'd135;

  localparam logic [7:0] BYTE_IDLE    = 8'hFF;
  localparam logic [7:0] R1_ERR_MASK  = 8'hFE;
  localparam logic [7:0] CRC_DEFAULT  = 8'h01;
  localparam logic [7:0] CMD_START    = 8'h40;
  localparam logic [7:0] CMD_LIMIT    = 8'd64;
  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_FRAME   = 5'b00010,
    PH_POLL    = 5'b00100,
    PH_COLLECT = 5'b01000,
    PH_TRAIL   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [8:0] poll_limit;
    logic [7:0] crc_cmd0;
    logic [7:0] crc_cmd8;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       resp_valid;
    logic [2:0] resp_index;
    logic [7:0] resp_byte;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

@@ sv/sdce_regs.sv @@
module sdce_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sdce_pkg::cfg_t      cfg
);
  import sdce_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_limit <= POLL_LIMIT_RST;
      cfg_r.crc_cmd0   <= CRC_CMD0_RST;
      cfg_r.crc_cmd8   <= CRC_CMD8_RST;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_POLL_LIMIT: cfg_r.poll_limit <= pwdata[8:0];
        REG_CRC_CMD0:   cfg_r.crc_cmd0   <= pwdata[7:0];
        REG_CRC_CMD8:   cfg_r.crc_cmd8   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_POLL_LIMIT: prdata = {23'd0, cfg_r.poll_limit};
      REG_CRC_CMD0:   prdata = {24'd0, cfg_r.crc_cmd0};
      REG_CRC_CMD8:   prdata = {24'd0, cfg_r.crc_cmd8};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ sv/sdce_core.sv @@
module sdce_core #(
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdce_pkg::cfg_t      cfg,
  input  logic                step,
  input  logic                operation,
  input  logic [7:0]          command_index,
  input  logic [31:0]         argument,
  input  logic [3:0]          response_length,
  input  logic [7:0]          rx_byte,
  output sdce_pkg::result_t   result
);
  import sdce_pkg::*;

  localparam logic [4:0] MAX_LEN = 5'(MAX_RESPONSE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [8:0]  poll_count_r, poll_count_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [2:0]  final_r, final_nxt;

  logic [8:0]  limit;
  logic [3:0]  len_sat;
  logic [3:0]  bc_inc;
  logic [7:0]  crc;

  assign limit  = (cfg.poll_limit == '0) ? 9'd1 : cfg.poll_limit;
  assign bc_inc = byte_count_r + 4'd1;

  always_comb begin
    if (response_length == '0)
      len_sat = 4'd1;
    else if ({1'b0, response_length} > MAX_LEN)
      len_sat = MAX_LEN[3:0];
    else
      len_sat = response_length;
  end

  always_comb begin
    if (cmd_r == CMD_GO_IDLE)
      crc = cfg.crc_cmd0;
    else if (cmd_r == CMD_IF_COND)
      crc = cfg.crc_cmd8;
    else
      crc = CRC_DEFAULT;
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    poll_count_nxt = poll_count_r;
    cmd_nxt        = cmd_r;
    arg_nxt        = arg_r;
    len_nxt        = len_r;
    final_nxt      = final_r;
    result         = '0;

    if (operation == OP_START) begin
      if (command_index >= CMD_LIMIT) begin
        phase_nxt       = PH_IDLE;
        final_nxt       = ST_ILLEGAL;
        result.done_res = 1'b1;
        result.status   = ST_ILLEGAL;
      end else begin
        cmd_nxt         = command_index[5:0];
        arg_nxt         = argument;
        len_nxt         = len_sat;
        byte_count_nxt  = 4'd1;
        poll_count_nxt  = '0;
        final_nxt       = ST_BUSY;
        phase_nxt       = PH_FRAME;
        result.tx_valid = 1'b1;
        result.tx_byte  = CMD_START | {2'b00, command_index[5:0]};
      end
    end else begin
      case (phase_r)
        PH_FRAME: begin
          result.tx_valid = 1'b1;
          case (byte_count_r)
            4'd1: begin result.tx_byte = arg_r[31:24]; byte_count_nxt = bc_inc; end
            4'd2: begin result.tx_byte = arg_r[23:16]; byte_count_nxt = bc_inc; end
            4'd3: begin result.tx_byte = arg_r[15:8];  byte_count_nxt = bc_inc; end
            4'd4: begin result.tx_byte = arg_r[7:0];   byte_count_nxt = bc_inc; end
            4'd5: begin result.tx_byte = crc;          byte_count_nxt = 4'd6;   end
            default: begin
              // frame sent, first poll goes out
              result.tx_byte = BYTE_IDLE;
              phase_nxt      = PH_POLL;
              poll_count_nxt = 9'd1;
            end
          endcase
        end
        PH_POLL: begin
          result.tx_valid = 1'b1;
          result.tx_byte  = BYTE_IDLE;
          if (rx_byte == BYTE_IDLE) begin
            if (poll_count_r >= limit) begin
              final_nxt = ST_TIMEOUT;
              phase_nxt = PH_TRAIL;
            end else begin
              poll_count_nxt = poll_count_r + 9'd1;
            end
          end else begin
            result.resp_valid = 1'b1;
            result.resp_byte  = rx_byte;
            if ((rx_byte & R1_ERR_MASK) != '0) begin
              final_nxt = ST_COMM;
              phase_nxt = PH_TRAIL;
            end else if (len_r > 4'd1) begin
              byte_count_nxt = 4'd1;
              phase_nxt      = PH_COLLECT;
            end else begin
              final_nxt = ST_OK;
              phase_nxt = PH_TRAIL;
            end
          end
        end
        PH_COLLECT: begin
          result.tx_valid   = 1'b1;
          result.tx_byte    = BYTE_IDLE;
          result.resp_valid = 1'b1;
          result.resp_index = byte_count_r[2:0];
          result.resp_byte  = rx_byte;
          byte_count_nxt    = bc_inc;
          if (bc_inc >= len_r) begin
            final_nxt = ST_OK;
            phase_nxt = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          phase_nxt       = PH_IDLE;
          result.done_res = 1'b1;
          result.status   = final_r;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      poll_count_r <= '0;
      cmd_r        <= '0;
      arg_r        <= '0;
      len_r        <= 4'd1;
      final_r      <= ST_BUSY;
    end else if (step) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      poll_count_r <= poll_count_nxt;
      cmd_r        <= cmd_nxt;
      arg_r        <= arg_nxt;
      len_r        <= len_nxt;
      final_r      <= final_nxt;
    end
  end

endmodule

@@ sv/sd_spi_command_response_engine_top.sv @@
// An accepted input beat's result beat is registered and appears in the next cycle.
// Throughput: one item per cycle; the single output register refills in the
// cycle it is drained, so input stalls only while a held result is stalled.
// Reset (rst_n low, synchronous): engine idle, output empty, registers at
// poll limit 256 and CRC bytes 0x95 / 0x87.
module sd_spi_command_response_engine_top #(
  parameter int MAX_RESPONSE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [3:0]  in_response_length,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_resp_valid,
  output logic [2:0]  out_resp_index,
  output logic [7:0]  out_resp_byte,
  output logic        out_done_res,
  output logic [2:0]  out_status
);
  import sdce_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  sdce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdce_core #(
    .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .step            (accept),
    .operation       (in_operation),
    .command_index   (in_command_index),
    .argument        (in_argument),
    .response_length (in_response_length),
    .rx_byte         (in_rx_byte),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_valid   = res_r.tx_valid;
  assign out_tx_byte    = res_r.tx_byte;
  assign out_resp_valid = res_r.resp_valid;
  assign out_resp_index = res_r.resp_index;
  assign out_resp_byte  = res_r.resp_byte;
  assign out_done_res   = res_r.done_res;
  assign out_status     = res_r.status;

endmodule
